/* sv/hpool_pkg.sv */
package hpool_pkg;

    // fixed field widths
    localparam int SIZE_W   = 11;
    localparam int FUNC_W   = 2;
    localparam int HANDLE_W = 32;
    localparam int GEN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 11;

    // generation memory entry: live flag over generation
    localparam int GEN_ENTRY_W = GEN_W + 1;

    // default slot count and pool size after reset
    localparam int POOL_DEPTH_DEF = 1024;
    localparam int POOL_SIZE_RST  = 1024;

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_VALIDATE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_STALE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

    // generation entry after a clear: not live, generation one
    localparam logic [GEN_ENTRY_W-1:0] GEN_ENTRY_CLEAR = {1'b0, 16'd1};

endpackage

/* sv/hpool_ram.sv */
module hpool_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/hpool_ctrl.sv */
module hpool_ctrl #(
    parameter int POOL_DEPTH = hpool_pkg::POOL_DEPTH_DEF,
    localparam int IDX_W = $clog2(POOL_DEPTH)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [hpool_pkg::FUNC_W-1:0]      s_func,
    input  logic [hpool_pkg::HANDLE_W-1:0]    s_handle_in,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [hpool_pkg::STATUS_W-1:0]    m_status,
    output logic [hpool_pkg::HANDLE_W-1:0]    m_handle_out,
    output logic [hpool_pkg::LIVE_W-1:0]      m_live_count,
    // size register
    input  logic                              cfg_we,
    input  logic [hpool_pkg::SIZE_W-1:0]      cfg_wdata,
    // free ring memory
    output logic                              ring_wr_en,
    output logic [IDX_W-1:0]                  ring_wr_addr,
    output logic [IDX_W-1:0]                  ring_wr_data,
    output logic                              ring_rd_en,
    output logic [IDX_W-1:0]                  ring_rd_addr,
    input  logic [IDX_W-1:0]                  ring_rd_data,
    // generation memory
    output logic                              gen_wr_en,
    output logic [IDX_W-1:0]                  gen_wr_addr,
    output logic [hpool_pkg::GEN_ENTRY_W-1:0] gen_wr_data,
    output logic                              gen_rd_en,
    output logic [IDX_W-1:0]                  gen_rd_addr,
    input  logic [hpool_pkg::GEN_ENTRY_W-1:0] gen_rd_data
);

    import hpool_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EXEC
    } state_t;

    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(POOL_DEPTH - 1);
    localparam logic [SIZE_W-1:0] SIZE_RST =
        (POOL_SIZE_RST > POOL_DEPTH) ? SIZE_W'(POOL_DEPTH) : SIZE_W'(POOL_SIZE_RST);

    state_t                state_reg,      state_next;
    logic [FUNC_W-1:0]     func_reg,       func_next;
    logic [HANDLE_W-1:0]   hin_reg,        hin_next;
    logic [SIZE_W-1:0]     size_reg,       size_next;
    logic [IDX_W-1:0]      head_reg,       head_next;
    logic [IDX_W-1:0]      tail_reg,       tail_next;
    logic [LIVE_W-1:0]     live_reg,       live_next;
    logic                  clr_active_reg, clr_active_next;
    logic [IDX_W-1:0]      clr_addr_reg,   clr_addr_next;
    logic                  m_valid_reg,    m_valid_next;
    logic [STATUS_W-1:0]   m_status_reg,   m_status_next;
    logic [HANDLE_W-1:0]   m_handle_reg,   m_handle_next;
    logic [LIVE_W-1:0]     m_live_reg,     m_live_next;

    logic [GEN_W-1:0]      req_idx;
    logic [GEN_W-1:0]      req_gen;
    logic                  in_range;
    logic [GEN_W-1:0]      slot_gen;
    logic                  slot_live;
    logic                  out_free;
    logic                  s_xfer;
    logic [SIZE_W-1:0]     cfg_size;
    logic [IDX_W-1:0]      head_adv;
    logic [IDX_W-1:0]      tail_adv;
    logic                  exec_ring_we;
    logic                  exec_gen_we;
    logic [IDX_W-1:0]      exec_gen_addr;
    logic [GEN_ENTRY_W-1:0] exec_gen_data;

    // step a ring pointer with wrap at the pool size
    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p,
                                                   input logic [SIZE_W-1:0] sz);
        logic [IDX_W-1:0] r;
        if (32'(p) + 32'd1 >= 32'(sz)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // request fields and memory read data
    assign req_idx   = hin_reg[GEN_W-1:0];
    assign req_gen   = hin_reg[HANDLE_W-1:GEN_W];
    assign in_range  = req_idx < 16'(size_reg);
    assign slot_gen  = gen_rd_data[GEN_W-1:0];
    assign slot_live = gen_rd_data[GEN_W];
    assign out_free  = !m_valid_reg || m_ready;
    assign head_adv  = ring_next(head_reg, size_reg);
    assign tail_adv  = ring_next(tail_reg, size_reg);

    assign s_ready = (state_reg == ST_IDLE) && !clr_active_reg;
    assign s_xfer  = s_valid && s_ready;

    // clamp a written size into the supported range
    always_comb begin
        cfg_size = cfg_wdata;
        if (cfg_wdata < SIZE_W'(2)) begin
            cfg_size = SIZE_W'(2);
        end
        if (32'(cfg_wdata) > POOL_DEPTH) begin
            cfg_size = SIZE_W'(POOL_DEPTH);
        end
    end

    // memory reads: ring head at transfer, generation in lookup
    assign ring_rd_en   = s_xfer;
    assign ring_rd_addr = head_reg;
    assign gen_rd_en    = (state_reg == ST_LOOKUP);
    assign gen_rd_addr  = (func_reg == FUNC_ALLOC) ? ring_rd_data : req_idx[IDX_W-1:0];

    // next state, pointers and result
    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        hin_next        = hin_reg;
        size_next       = size_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        live_next       = live_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_handle_next   = m_handle_reg;
        m_live_next     = m_live_reg;
        exec_ring_we    = 1'b0;
        exec_gen_we     = 1'b0;
        exec_gen_addr   = req_idx[IDX_W-1:0];
        exec_gen_data   = {1'b0, slot_gen + 16'd1};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    func_next  = s_func;
                    hin_next   = s_handle_in;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (out_free) begin
                    state_next    = ST_IDLE;
                    m_valid_next  = 1'b1;
                    m_status_next = STAT_OK;
                    m_handle_next = '0;
                    case (func_reg)
                        FUNC_ALLOC: begin
                            if (head_reg == tail_reg) begin
                                m_status_next = STAT_EMPTY;
                            end else begin
                                head_next     = head_adv;
                                exec_gen_we   = 1'b1;
                                exec_gen_addr = ring_rd_data;
                                exec_gen_data = {1'b1, slot_gen};
                                m_handle_next = {slot_gen, 16'(ring_rd_data)};
                                live_next     = live_reg + 1'b1;
                            end
                        end
                        FUNC_FREE: begin
                            if (!in_range) begin
                                m_status_next = STAT_RANGE;
                            end else if (slot_gen != req_gen || !slot_live) begin
                                m_status_next = STAT_STALE;
                            end else begin
                                exec_gen_we   = 1'b1;
                                exec_ring_we  = 1'b1;
                                tail_next     = tail_adv;
                                live_next     = live_reg - 1'b1;
                                m_handle_next = hin_reg;
                            end
                        end
                        FUNC_VALIDATE: begin
                            if (!in_range) begin
                                m_status_next = STAT_RANGE;
                            end else if (slot_gen != req_gen) begin
                                m_status_next = STAT_STALE;
                            end else begin
                                m_handle_next = hin_reg;
                            end
                        end
                        default: begin
                            m_status_next = STAT_OK;
                        end
                    endcase
                    m_live_next = live_next;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // clearing sweep over every entry
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR) begin
                clr_active_next = 1'b0;
            end
        end

        // size write restarts the pool
        if (cfg_we) begin
            size_next       = cfg_size;
            head_next       = '0;
            tail_next       = IDX_W'(cfg_size - 1'b1);
            live_next       = '0;
            clr_active_next = 1'b1;
            clr_addr_next   = '0;
        end
    end

    // memory writes: clearing sweep or result write-back
    always_comb begin
        if (clr_active_reg) begin
            ring_wr_en   = 1'b1;
            ring_wr_addr = clr_addr_reg;
            ring_wr_data = clr_addr_reg;
            gen_wr_en    = 1'b1;
            gen_wr_addr  = clr_addr_reg;
            gen_wr_data  = GEN_ENTRY_CLEAR;
        end else begin
            ring_wr_en   = exec_ring_we;
            ring_wr_addr = tail_adv;
            ring_wr_data = req_idx[IDX_W-1:0];
            gen_wr_en    = exec_gen_we;
            gen_wr_addr  = exec_gen_addr;
            gen_wr_data  = exec_gen_data;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            size_reg       <= SIZE_RST;
            head_reg       <= '0;
            tail_reg       <= IDX_W'(SIZE_RST - 1'b1);
            live_reg       <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            size_reg       <= size_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            live_reg       <= live_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            m_valid_reg    <= m_valid_next;
        end
        func_reg     <= func_next;
        hin_reg      <= hin_next;
        m_status_reg <= m_status_next;
        m_handle_reg <= m_handle_next;
        m_live_reg   <= m_live_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_handle_out = m_handle_reg;
    assign m_live_count = m_live_reg;

endmodule

/* sv/generational_handle_pool_top.sv */
// channel   direction  ports
// request   in         s_valid s_ready s_func s_handle_in
// result    out        m_valid m_ready m_status m_handle_out m_live_count
// size reg  in         cfg_we cfg_wdata
//
// each request passes through a ring read, a generation read, then write-back
// and result; the dependent lookup of the generation by the popped ring slot sets this order.
// after reset and after every size write a clearing pass writes all POOL_DEPTH
// entries of both memories, one per cycle, with s_ready low until the pass ends.
// a waiting result does not block the next transfer in; a request stalls in its
// last cycle until the result register is free.
module generational_handle_pool_top #(
    parameter int POOL_DEPTH = hpool_pkg::POOL_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [hpool_pkg::FUNC_W-1:0]   s_func,
    input  logic [hpool_pkg::HANDLE_W-1:0] s_handle_in,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hpool_pkg::STATUS_W-1:0] m_status,
    output logic [hpool_pkg::HANDLE_W-1:0] m_handle_out,
    output logic [hpool_pkg::LIVE_W-1:0]   m_live_count,
    input  logic                           cfg_we,
    input  logic [hpool_pkg::SIZE_W-1:0]   cfg_wdata
);

    import hpool_pkg::*;

    localparam int IDX_W = $clog2(POOL_DEPTH);

    logic                   ring_wr_en;
    logic [IDX_W-1:0]       ring_wr_addr;
    logic [IDX_W-1:0]       ring_wr_data;
    logic                   ring_rd_en;
    logic [IDX_W-1:0]       ring_rd_addr;
    logic [IDX_W-1:0]       ring_rd_data;
    logic                   gen_wr_en;
    logic [IDX_W-1:0]       gen_wr_addr;
    logic [GEN_ENTRY_W-1:0] gen_wr_data;
    logic                   gen_rd_en;
    logic [IDX_W-1:0]       gen_rd_addr;
    logic [GEN_ENTRY_W-1:0] gen_rd_data;

    // sequencer, pointers and result register
    hpool_ctrl #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_handle_in  (s_handle_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_handle_out (m_handle_out),
        .m_live_count (m_live_count),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .ring_wr_en   (ring_wr_en),
        .ring_wr_addr (ring_wr_addr),
        .ring_wr_data (ring_wr_data),
        .ring_rd_en   (ring_rd_en),
        .ring_rd_addr (ring_rd_addr),
        .ring_rd_data (ring_rd_data),
        .gen_wr_en    (gen_wr_en),
        .gen_wr_addr  (gen_wr_addr),
        .gen_wr_data  (gen_wr_data),
        .gen_rd_en    (gen_rd_en),
        .gen_rd_addr  (gen_rd_addr),
        .gen_rd_data  (gen_rd_data)
    );

    // free index ring
    hpool_ram #(
        .WIDTH (IDX_W),
        .DEPTH (POOL_DEPTH)
    ) u_ring_ram (
        .aclk    (aclk),
        .wr_en   (ring_wr_en),
        .wr_addr (ring_wr_addr),
        .wr_data (ring_wr_data),
        .rd_en   (ring_rd_en),
        .rd_addr (ring_rd_addr),
        .rd_data (ring_rd_data)
    );

    // per-slot generation and live flag
    hpool_ram #(
        .WIDTH (GEN_ENTRY_W),
        .DEPTH (POOL_DEPTH)
    ) u_gen_ram (
        .aclk    (aclk),
        .wr_en   (gen_wr_en),
        .wr_addr (gen_wr_addr),
        .wr_data (gen_wr_data),
        .rd_en   (gen_rd_en),
        .rd_addr (gen_rd_addr),
        .rd_data (gen_rd_data)
    );

endmodule
